// ----- hw/rtl/smdf_pkg.sv -----
// shared constants, register codes and the sine table for the flanger
package smdf_pkg;

  localparam int MAX_LINE_DEF    = 1024;
  localparam int SINE_TABLE_SIZE = 512;
  localparam int SINE_BITS       = $clog2(SINE_TABLE_SIZE);
  localparam int SINE_IDX_W      = SINE_BITS + 1;

  localparam int LEN_W   = 11;
  localparam int OFF_W   = 11;
  localparam int DEPTH_W = 10;
  localparam int PHASE_W = 31;
  localparam int SAMP_W  = 16;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 31;

  // tap arithmetic: pointer and offset below 2048, swing below 2048
  localparam int TAP_W = 14;
  localparam int MAG_W = TAP_W - 1;
  localparam int M_W   = 13;

  localparam longint unsigned PI_HALF_Q30 = 64'd1686629713;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_LINE_LENGTH = 2'd0,
    REG_TAP_OFFSET  = 2'd1,
    REG_SWEEP_DEPTH = 2'd2,
    REG_PHASE_STEP  = 2'd3
  } cfg_reg_t;

  typedef logic signed [SAMP_W-1:0] sine_tab_t [0:SINE_TABLE_SIZE];

  // round(32768 * sin(pi/2 * num / size)), q30 taylor series
  function automatic int quarter_sine(longint unsigned num);
    longint unsigned x, x2, term;
    longint sum, q;
    begin
      x = (num * PI_HALF_Q30) / SINE_TABLE_SIZE;
      x2 = (x * x) >> 30;
      term = x;
      sum = longint'(x);
      // ten series terms after the first, divisors (2k)(2k+1)
      term = ((term * x2) >> 30) / 64'd6;
      sum = sum - longint'(term);
      term = ((term * x2) >> 30) / 64'd20;
      sum = sum + longint'(term);
      term = ((term * x2) >> 30) / 64'd42;
      sum = sum - longint'(term);
      term = ((term * x2) >> 30) / 64'd72;
      sum = sum + longint'(term);
      term = ((term * x2) >> 30) / 64'd110;
      sum = sum - longint'(term);
      term = ((term * x2) >> 30) / 64'd156;
      sum = sum + longint'(term);
      term = ((term * x2) >> 30) / 64'd210;
      sum = sum - longint'(term);
      term = ((term * x2) >> 30) / 64'd272;
      sum = sum + longint'(term);
      term = ((term * x2) >> 30) / 64'd342;
      sum = sum - longint'(term);
      term = ((term * x2) >> 30) / 64'd420;
      sum = sum + longint'(term);
      if (sum < 0) sum = 0;
      q = (sum + (1 << 14)) >>> 15;
      if (q > 32767) q = 32767;
      return int'(q);
    end
  endfunction

  function automatic sine_tab_t build_sine();
    sine_tab_t t;
    int quad, rem, v;
    begin
      for (int i = 0; i <= SINE_TABLE_SIZE; i++) begin
        quad = ((4 * i) / SINE_TABLE_SIZE) & 3;
        rem  = (4 * i) % SINE_TABLE_SIZE;
        if (quad == 0 || quad == 2) v = quarter_sine(longint'(rem));
        else v = quarter_sine(longint'(SINE_TABLE_SIZE - rem));
        if (quad >= 2) v = -v;
        t[i] = SAMP_W'(v);
      end
      return t;
    end
  endfunction

  localparam sine_tab_t SINE_TAB = build_sine();

endpackage

// ----- hw/rtl/smdf_ram.sv -----
// generic single-write, single-read ram with registered read data
module smdf_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [0:DEPTH-1];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- hw/rtl/smdf_mod.sv -----
// iterative remainder unit, one dividend bit per cycle
module smdf_mod import smdf_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [MAG_W-1:0] dividend,
  input  logic [LEN_W-1:0] divisor,
  output logic             done,
  output logic [LEN_W-1:0] remainder
);

  localparam int CNT_W = $clog2(MAG_W);

  logic             busy;
  logic [CNT_W-1:0] cnt;
  logic [MAG_W-1:0] quo;
  logic [LEN_W-1:0] rem;
  logic [LEN_W:0]   trial;

  assign trial = {rem, quo[MAG_W-1]};
  assign remainder = rem;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CNT_W'(MAG_W - 1);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo <= dividend;
      rem <= '0;
    end else if (busy) begin
      quo <= quo << 1;
      if (trial >= {1'b0, divisor}) rem <= LEN_W'(trial - {1'b0, divisor});
      else rem <= trial[LEN_W-1:0];
    end
  end

endmodule

// ----- hw/rtl/sine_modulated_delay_flanger.sv -----
// Flanger: each word is stored in a circular delay line and, outside passthrough, mixed 50/50
// with a tap that a table-interpolated sine sweeps behind the write pointer. In passthrough
// (tap offset -1) the word goes straight to the output; otherwise it passes the sine table,
// the 13-step tap remainder unit and the two delay-line reads, and a stalled output holds it.
// A new word is taken only once the last has left. After reset the delay line is cleared one
// entry a cycle, during which no word is taken; configuration writes are always taken.
module sine_modulated_delay_flanger import smdf_pkg::*; #(
  parameter int MAX_LINE = MAX_LINE_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic signed [SAMP_W-1:0]     sample_in,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic signed [SAMP_W-1:0]     sample_out,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [CFG_IDX_W-1:0]         cfg_index,
  input  logic [CFG_DATA_W-1:0]        cfg_data
);

  localparam int AW = $clog2(MAX_LINE);

  typedef enum logic [11:0] {
    S_CLEAR = 12'b000000000001,
    S_IDLE  = 12'b000000000010,
    S_TAB0  = 12'b000000000100,
    S_TAB1  = 12'b000000001000,
    S_SINE  = 12'b000000010000,
    S_DEPTH = 12'b000000100000,
    S_TAP   = 12'b000001000000,
    S_MOD   = 12'b000010000000,
    S_RDA   = 12'b000100000000,
    S_RDB   = 12'b001000000000,
    S_MIX   = 12'b010000000000,
    S_OUT   = 12'b100000000000
  } state_t;

  state_t state, state_next;

  logic [LEN_W-1:0]          line_length;
  logic signed [OFF_W-1:0]   tap_offset;
  logic [DEPTH_W-1:0]        sweep_depth;
  logic [PHASE_W-1:0]        phase_step;

  logic [AW-1:0]             wp;
  logic [PHASE_W-1:0]        phase;
  logic [AW-1:0]             clr_addr;

  logic signed [SAMP_W-1:0]  dry;
  logic [LEN_W-1:0]          len;
  logic [LEN_W-1:0]          off;
  logic signed [SAMP_W-1:0]  tab_a, tab_b;
  logic signed [16:0]        amp_a;
  logic signed [17:0]        sine;
  logic signed [M_W-1:0]     swing;
  logic                      tap_neg;
  logic [LEN_W-1:0]          idx0, idx1;
  logic signed [SAMP_W-1:0]  samp_a;
  logic signed [SAMP_W-1:0]  result;

  logic [LEN_W-1:0]          len_eff;
  logic [LEN_W-1:0]          off_eff;
  logic                      pass;
  logic [AW:0]               wp_plus;
  logic [AW-1:0]             wp_next;
  logic                      accept;

  logic [SINE_BITS+14:0]     ph_scaled;
  logic [SINE_IDX_W-1:0]     tab_k;
  logic [14:0]               tab_f;
  logic signed [32:0]        prod_a;
  logic signed [31:0]        prod_b;
  logic signed [28:0]        prod_m;
  logic signed [TAP_W-1:0]   tap;
  logic [MAG_W-1:0]          tap_mag;

  logic                      mod_start, mod_done;
  logic [LEN_W-1:0]          mod_rem;
  logic [LEN_W-1:0]          i0_calc, i1_calc;

  logic signed [16:0]        diff;
  logic signed [32:0]        prod_f;
  logic signed [17:0]        term;
  logic signed [18:0]        sum;
  logic signed [18:0]        half;

  logic                      ram_we;
  logic [AW-1:0]             ram_waddr, ram_raddr;
  logic [SAMP_W-1:0]         ram_wdata, ram_rdata;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      line_length <= LEN_W'(1024);
      tap_offset  <= -11'sd1;
      sweep_depth <= '0;
      phase_step  <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_LINE_LENGTH: line_length <= cfg_data[LEN_W-1:0];
        REG_TAP_OFFSET:  tap_offset  <= $signed(cfg_data[OFF_W-1:0]);
        REG_SWEEP_DEPTH: sweep_depth <= cfg_data[DEPTH_W-1:0];
        REG_PHASE_STEP:  phase_step  <= cfg_data[PHASE_W-1:0];
        default: ;
      endcase
    end
  end

  // effective length, offset, passthrough flag and next write pointer for the word being taken
  always_comb begin
    if (line_length == '0) len_eff = LEN_W'(1);
    else if (32'(line_length) > MAX_LINE) len_eff = LEN_W'(MAX_LINE);
    else len_eff = line_length;
    pass = (tap_offset == -11'sd1);
    if (tap_offset < 0) off_eff = '0;
    else if ($signed({1'b0, tap_offset}) >= $signed({1'b0, len_eff})) off_eff = len_eff - 1'b1;
    else off_eff = LEN_W'(tap_offset);
    wp_plus = {1'b0, wp} + 1'b1;
    wp_next = (32'(wp_plus) >= 32'(len_eff)) ? '0 : wp_plus[AW-1:0];
  end

  assign in_stall = (state != S_IDLE);
  assign accept = in_valid && !in_stall;

  // sine table position from phase bits 30..16
  assign ph_scaled = {phase[30:16], {SINE_BITS{1'b0}}};
  assign tab_k = {1'b0, ph_scaled[SINE_BITS+14:15]};
  assign tab_f = ph_scaled[14:0];

  assign prod_a = $signed({1'b0, 16'(17'h08000 - {2'b0, tab_f})}) * tab_a;
  assign prod_b = $signed({1'b0, tab_f}) * tab_b;
  assign prod_m = sine * $signed({1'b0, sweep_depth});

  assign tap = TAP_W'(wp) - TAP_W'(off) - TAP_W'(swing);
  assign tap_mag = tap[TAP_W-1] ? MAG_W'(-tap) : MAG_W'(tap);
  assign mod_start = (state == S_TAP);

  smdf_mod u_mod (
    .clk       (clk),
    .rst       (rst),
    .start     (mod_start),
    .dividend  (tap_mag),
    .divisor   (len),
    .done      (mod_done),
    .remainder (mod_rem)
  );

  // fold the sign back and pick the neighbor entry
  always_comb begin
    if (tap_neg && mod_rem != '0) i0_calc = len - mod_rem;
    else if (tap_neg) i0_calc = '0;
    else i0_calc = mod_rem;
    if (sine < 0) i1_calc = (i0_calc == '0) ? len - 1'b1 : i0_calc - 1'b1;
    else i1_calc = (i0_calc + 1'b1 == len) ? '0 : i0_calc + 1'b1;
  end

  assign diff = 17'($signed(ram_rdata)) - 17'(samp_a);
  assign prod_f = diff * $signed({1'b0, phase[15:1]});
  assign term = 18'(prod_f >>> 15);
  assign sum = 19'(dry) + 19'(samp_a) + 19'(term);
  assign half = (sum + (sum < 0 ? 19'sd1 : 19'sd0)) >>> 1;

  always_comb begin
    state_next = state;
    unique case (state)
      S_CLEAR: if (clr_addr == AW'(MAX_LINE - 1)) state_next = S_IDLE;
      S_IDLE:  if (accept) state_next = pass ? S_OUT : S_TAB0;
      S_TAB0:  state_next = S_TAB1;
      S_TAB1:  state_next = S_SINE;
      S_SINE:  state_next = S_DEPTH;
      S_DEPTH: state_next = S_TAP;
      S_TAP:   state_next = S_MOD;
      S_MOD:   if (mod_done) state_next = S_RDA;
      S_RDA:   state_next = S_RDB;
      S_RDB:   state_next = S_MIX;
      S_MIX:   state_next = S_OUT;
      S_OUT:   if (!out_valid || !out_stall) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      clr_addr  <= '0;
      wp        <= '0;
      phase     <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == S_CLEAR) clr_addr <= clr_addr + 1'b1;
      if (accept) wp <= wp_next;
      if (state == S_MIX) phase <= PHASE_W'(phase + phase_step);
      if (state == S_OUT && (!out_valid || !out_stall)) out_valid <= 1'b1;
      else if (!out_stall) out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      dry    <= sample_in;
      len    <= len_eff;
      off    <= off_eff;
      result <= sample_in;
    end
    if (state == S_TAB0) tab_a <= SINE_TAB[tab_k];
    if (state == S_TAB1) begin
      tab_b <= SINE_TAB[tab_k + 1'b1];
      amp_a <= 17'(prod_a >>> 16);
    end
    if (state == S_SINE) sine <= 18'(amp_a + 17'(prod_b >>> 16)) <<< 1;
    if (state == S_DEPTH) swing <= M_W'(prod_m >>> 15);
    if (state == S_TAP) tap_neg <= tap[TAP_W-1];
    if (state == S_MOD && mod_done) begin
      idx0 <= i0_calc;
      idx1 <= i1_calc;
    end
    if (state == S_RDB) samp_a <= ram_rdata;
    if (state == S_MIX) result <= half[SAMP_W-1:0];
    if (state == S_OUT && (!out_valid || !out_stall)) sample_out <= result;
  end

  // clear pass, then one store per word; reads only touch entries after the store
  always_comb begin
    ram_we    = (state == S_CLEAR) || accept;
    ram_waddr = (state == S_CLEAR) ? clr_addr : wp_next;
    ram_wdata = (state == S_CLEAR) ? '0 : sample_in;
    ram_raddr = (state == S_RDB) ? AW'(idx1) : AW'(idx0);
  end

  smdf_ram #(
    .WIDTH (SAMP_W),
    .DEPTH (MAX_LINE)
  ) u_line (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

endmodule
